@@ rtl/core/olt_pkg.sv @@
// ----------------------------------------------------------------------------
// olt_pkg
// Shared types and constants of the ordered list table: request codes,
// status codes, the classified command and the back-end states.
// ----------------------------------------------------------------------------
package olt_pkg;

  localparam int REQ_W       = 4;
  localparam int POS_W       = 6;
  localparam int ST_W        = 2;
  localparam int LEN_W       = 5;
  localparam int DEPTH_DEF   = 16;
  localparam int KEY_W_DEF   = 16;
  localparam int PAY_W_DEF   = 32;
  localparam int QUEUE_DEPTH = 2;

  // request codes
  localparam logic [REQ_W-1:0] REQ_INSERT_AT  = 4'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 4'd1;
  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 4'd2;
  localparam logic [REQ_W-1:0] REQ_DELETE_AT  = 4'd3;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 4'd4;
  localparam logic [REQ_W-1:0] REQ_POP_BACK   = 4'd5;
  localparam logic [REQ_W-1:0] REQ_GET        = 4'd6;
  localparam logic [REQ_W-1:0] REQ_LOCATE     = 4'd7;
  localparam logic [REQ_W-1:0] REQ_CLEAR      = 4'd8;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BADPOS   = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_INSERT,
    OP_DELETE,
    OP_GET,
    OP_LOCATE,
    OP_CLEAR
  } op_t;

  // where the position of a request comes from
  typedef enum logic [1:0] {
    PSEL_GIVEN,
    PSEL_FIRST,
    PSEL_LAST
  } pos_sel_t;

  typedef struct packed {
    op_t              op;
    pos_sel_t         psel;
    logic [POS_W-1:0] pos;
  } cmd_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_RUN,
    B_WRITE,
    B_RESULT
  } back_state_t;

endpackage

@@ rtl/core/olt_front.sv @@
// ----------------------------------------------------------------------------
// olt_front
// Request front end: takes a transaction when the queue has room and turns
// the request code into an operation and a position source.
// ----------------------------------------------------------------------------
module olt_front #(
  parameter int KEY_WIDTH     = olt_pkg::KEY_W_DEF,
  parameter int PAYLOAD_WIDTH = olt_pkg::PAY_W_DEF
) (
  input  logic                      start,
  output logic                      busy,
  input  logic [olt_pkg::REQ_W-1:0] req_type,
  input  logic [olt_pkg::POS_W-1:0] position,
  input  logic [KEY_WIDTH-1:0]      elem_key,
  input  logic [PAYLOAD_WIDTH-1:0]  elem_payload,
  input  logic                      q_full,
  output logic                      push,
  output olt_pkg::cmd_t             push_cmd,
  output logic [KEY_WIDTH-1:0]      push_key,
  output logic [PAYLOAD_WIDTH-1:0]  push_pay
);
  import olt_pkg::*;

  assign busy     = q_full;
  assign push     = start && !q_full;
  assign push_key = elem_key;
  assign push_pay = elem_payload;

  always_comb begin
    push_cmd.pos  = position;
    push_cmd.op   = OP_NOP;
    push_cmd.psel = PSEL_GIVEN;
    case (req_type)
      REQ_INSERT_AT: begin
        push_cmd.op = OP_INSERT;
      end
      REQ_PUSH_FRONT: begin
        push_cmd.op   = OP_INSERT;
        push_cmd.psel = PSEL_FIRST;
      end
      REQ_PUSH_BACK: begin
        push_cmd.op   = OP_INSERT;
        push_cmd.psel = PSEL_LAST;
      end
      REQ_DELETE_AT: begin
        push_cmd.op = OP_DELETE;
      end
      REQ_POP_FRONT: begin
        push_cmd.op   = OP_DELETE;
        push_cmd.psel = PSEL_FIRST;
      end
      REQ_POP_BACK: begin
        push_cmd.op   = OP_DELETE;
        push_cmd.psel = PSEL_LAST;
      end
      REQ_GET: begin
        push_cmd.op = OP_GET;
      end
      REQ_LOCATE: begin
        push_cmd.op = OP_LOCATE;
      end
      REQ_CLEAR: begin
        push_cmd.op = OP_CLEAR;
      end
      default: begin
        push_cmd.op = OP_NOP;
      end
    endcase
  end

endmodule

@@ rtl/core/olt_queue.sv @@
// ----------------------------------------------------------------------------
// olt_queue
// Small command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module olt_queue #(
  parameter int DATA_W = 8,
  parameter int QDEPTH = olt_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic              valid,
  output logic [DATA_W-1:0] head
);
  import olt_pkg::*;

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int FILL_W = $clog2(QDEPTH + 1);

  logic [DATA_W-1:0] slots [QDEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;

  assign full  = (fill == FILL_W'(QDEPTH));
  assign valid = (fill != '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + FILL_W'(1);
      end else if (pop && !push) begin
        fill <= fill - FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

@@ rtl/core/olt_back.sv @@
// ----------------------------------------------------------------------------
// olt_back
// Execution back end: holds the entry memory and the length, moves entries
// one per cycle for insert and delete, scans keys one per cycle for locate.
// ----------------------------------------------------------------------------
module olt_back #(
  parameter int DEPTH         = olt_pkg::DEPTH_DEF,
  parameter int KEY_WIDTH     = olt_pkg::KEY_W_DEF,
  parameter int PAYLOAD_WIDTH = olt_pkg::PAY_W_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_valid,
  output logic                      q_pop,
  input  olt_pkg::cmd_t             q_cmd,
  input  logic [KEY_WIDTH-1:0]      q_key,
  input  logic [PAYLOAD_WIDTH-1:0]  q_pay,
  output logic                      done,
  output logic [olt_pkg::ST_W-1:0]  status,
  output logic [olt_pkg::LEN_W-1:0] found_position,
  output logic [KEY_WIDTH-1:0]      out_key,
  output logic [PAYLOAD_WIDTH-1:0]  out_payload,
  output logic [olt_pkg::LEN_W-1:0] list_length,
  output logic                      list_empty
);
  import olt_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

  logic [KEY_WIDTH-1:0]     mem_key [DEPTH];
  logic [PAYLOAD_WIDTH-1:0] mem_pay [DEPTH];

  back_state_t              state;
  back_state_t              state_next;
  logic [CNT_W-1:0]         cnt;
  logic                     issuing;
  logic                     rd_vld_q;

  op_t                      op_q;
  logic                     dir_up;
  logic [AW-1:0]            idx;
  logic [AW-1:0]            end_idx;
  logic [AW-1:0]            ins_addr;
  logic [AW-1:0]            rd_addr_q;
  logic [KEY_WIDTH-1:0]     key_q;
  logic [PAYLOAD_WIDTH-1:0] pay_q;
  logic [KEY_WIDTH-1:0]     rd_key;
  logic [PAYLOAD_WIDTH-1:0] rd_pay;
  status_t                  res_status;
  logic [LEN_W-1:0]         res_found;
  logic [KEY_WIDTH-1:0]     res_key;
  logic [PAYLOAD_WIDTH-1:0] res_pay;

  logic                     take;
  logic [PW-1:0]            cnt_p;
  logic [PW-1:0]            pos_p;
  logic [PW-1:0]            p_res;
  logic [PW-1:0]            p_m1;
  logic [PW-1:0]            cnt_m1;
  logic                     is_full;
  logic                     ins_bad;
  logic                     rng_bad;
  back_state_t              take_next;
  status_t                  take_status;
  logic [AW-1:0]            take_idx;
  logic [AW-1:0]            take_end;
  logic                     take_up;
  logic                     tail_pop;

  logic                     rd_en;
  logic                     match;
  logic                     run_done;
  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  logic [KEY_WIDTH-1:0]     wr_key;
  logic [PAYLOAD_WIDTH-1:0] wr_pay;

  assign take  = (state == B_IDLE) && q_valid;
  assign q_pop = take;

  // resolve the position against the current length
  always_comb begin
    cnt_p  = PW'(cnt);
    pos_p  = PW'(q_cmd.pos);
    cnt_m1 = cnt_p - PW'(1);
    case (q_cmd.psel)
      PSEL_GIVEN: p_res = pos_p;
      PSEL_FIRST: p_res = PW'(1);
      PSEL_LAST:  p_res = (q_cmd.op == OP_INSERT) ? cnt_p + PW'(1) : cnt_p;
      default:    p_res = pos_p;
    endcase
    p_m1    = p_res - PW'(1);
    is_full = (cnt == CNT_W'(DEPTH));
    ins_bad = (p_res == '0) || (p_res > cnt_p + PW'(1));
    rng_bad = (p_res == '0) || (p_res > cnt_p);
  end

  // classify the queued command
  always_comb begin
    take_next   = B_RESULT;
    take_status = ST_OK;
    take_idx    = p_m1[AW-1:0];
    take_end    = p_m1[AW-1:0];
    take_up     = 1'b1;
    tail_pop    = 1'b0;
    case (q_cmd.op)
      OP_INSERT: begin
        take_idx = cnt_m1[AW-1:0];
        take_up  = 1'b0;
        if (is_full) begin
          take_status = ST_FULL;
        end else if (ins_bad) begin
          take_status = ST_BADPOS;
        end else if (p_res == cnt_p + PW'(1)) begin
          take_next = B_WRITE;
        end else begin
          take_next = B_RUN;
        end
      end
      OP_DELETE: begin
        take_idx = p_res[AW-1:0];
        take_end = cnt_m1[AW-1:0];
        if (rng_bad) begin
          take_status = ST_BADPOS;
        end else if (p_res == cnt_p) begin
          tail_pop = 1'b1;
        end else begin
          take_next = B_RUN;
        end
      end
      OP_GET: begin
        if (rng_bad) begin
          take_status = ST_BADPOS;
        end else begin
          take_next = B_RUN;
        end
      end
      OP_LOCATE: begin
        take_idx    = '0;
        take_end    = cnt_m1[AW-1:0];
        take_status = ST_NOTFOUND;
        if (cnt != '0) begin
          take_next = B_RUN;
        end
      end
      default: begin
        take_next = B_RESULT;
      end
    endcase
  end

  assign rd_en = (state == B_RUN) && issuing;
  assign match = rd_vld_q && (rd_key == key_q);

  always_comb begin
    run_done = 1'b0;
    if (state == B_RUN) begin
      if (op_q == OP_LOCATE) begin
        run_done = match || (!issuing && rd_vld_q);
      end else begin
        run_done = !issuing && rd_vld_q;
      end
    end
  end

  // memory write port: moved entries while running, then the new entry at its position
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rd_addr_q - AW'(1);
    wr_key  = rd_key;
    wr_pay  = rd_pay;
    if (state == B_WRITE) begin
      wr_en   = 1'b1;
      wr_addr = ins_addr;
      wr_key  = key_q;
      wr_pay  = pay_q;
    end else if ((state == B_RUN) && rd_vld_q) begin
      if (op_q == OP_INSERT) begin
        wr_en   = 1'b1;
        wr_addr = rd_addr_q + AW'(1);
      end else if (op_q == OP_DELETE) begin
        wr_en = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_key[wr_addr] <= wr_key;
      mem_pay[wr_addr] <= wr_pay;
    end
    if (rd_en) begin
      rd_key <= mem_key[idx];
      rd_pay <= mem_pay[idx];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE:   state_next = take ? take_next : B_IDLE;
      B_RUN: begin
        if (run_done) begin
          state_next = (op_q == OP_INSERT) ? B_WRITE : B_RESULT;
        end
      end
      B_WRITE:  state_next = B_RESULT;
      B_RESULT: state_next = B_IDLE;
      default:  state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_IDLE;
      cnt      <= '0;
      issuing  <= 1'b0;
      rd_vld_q <= 1'b0;
    end else begin
      state    <= state_next;
      rd_vld_q <= rd_en;
      if (take) begin
        issuing <= (take_next == B_RUN);
        if (q_cmd.op == OP_CLEAR) begin
          cnt <= '0;
        end else if (tail_pop) begin
          cnt <= cnt - CNT_W'(1);
        end
      end else if (run_done) begin
        issuing <= 1'b0;
        if (op_q == OP_DELETE) begin
          cnt <= cnt - CNT_W'(1);
        end
      end else if (rd_en && (idx == end_idx)) begin
        issuing <= 1'b0;
      end
      if (state == B_WRITE) begin
        cnt <= cnt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_q <= idx;
    if (take) begin
      op_q       <= q_cmd.op;
      key_q      <= q_key;
      pay_q      <= q_pay;
      idx        <= take_idx;
      end_idx    <= take_end;
      dir_up     <= take_up;
      ins_addr   <= p_m1[AW-1:0];
      res_status <= take_status;
      res_found  <= '0;
      res_key    <= '0;
      res_pay    <= '0;
    end else begin
      if (rd_en) begin
        idx <= dir_up ? idx + AW'(1) : idx - AW'(1);
      end
      if ((state == B_RUN) && rd_vld_q && (op_q == OP_GET)) begin
        res_key <= rd_key;
        res_pay <= rd_pay;
      end
      if ((state == B_RUN) && (op_q == OP_LOCATE) && match) begin
        res_status <= ST_OK;
        res_found  <= LEN_W'({1'b0, rd_addr_q} + (AW + 1)'(1));
      end
    end
  end

  always_comb begin
    done           = (state == B_RESULT);
    status         = res_status;
    found_position = res_found;
    out_key        = res_key;
    out_payload    = res_pay;
    list_length    = LEN_W'(cnt);
    list_empty     = (cnt == '0);
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(DEPTH))
    else $error("list length above depth");

  a_read_only: assert property (@(posedge clk) disable iff (rst)
    (state == B_RUN && (op_q == OP_GET || op_q == OP_LOCATE)) |-> !wr_en)
    else $error("memory write during get or locate");

  a_read_in_list: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> ((CNT_W + 1)'(idx) < (CNT_W + 1)'(cnt)))
    else $error("entry read beyond list length");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (state == B_WRITE) |=> (done && cnt == CNT_W'($past(cnt) + CNT_W'(1))))
    else $error("insert did not finish with length plus one");
`endif

endmodule

@@ rtl/core/ordered_list_table_unit.sv @@
// ----------------------------------------------------------------------------
// ordered_list_table_unit
// Bounded ordered list of key/payload entries with positional insert and
// delete, get, locate by key and clear.
// ----------------------------------------------------------------------------
// Usage: drive req_type, position, elem_key and elem_payload and raise start;
// the transaction is taken at a rising edge with start high and busy low.
// Up to two transactions wait in a command queue while the back end works,
// so busy only rises when that queue is full.
// Each transaction gives one result, shown for exactly one cycle with done
// high: status, found_position, out_key, out_payload, list_length and
// list_empty. Results come out in request order and cannot be held off.
// With the back end idle, errors, clear, removing the last entry and unused
// codes go straight to the result, and an append writes the new entry first.
// Other requests read entries from the entry memory (one read port and one
// write port): get reads one entry, delete moves the entries behind the
// position, locate compares keys up to a match, and insert moves entries
// up and then does one final write. The back end takes the next queued
// transaction in the cycle after each result, so it works on one at a time.
// Reset (rst, synchronous) empties the list and the queue; entry contents
// are not cleared, since no entry is read before it has been written.
// ----------------------------------------------------------------------------
module ordered_list_table_unit #(
  parameter int DEPTH         = olt_pkg::DEPTH_DEF,
  parameter int KEY_WIDTH     = olt_pkg::KEY_W_DEF,
  parameter int PAYLOAD_WIDTH = olt_pkg::PAY_W_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [olt_pkg::REQ_W-1:0] req_type,
  input  logic [olt_pkg::POS_W-1:0] position,
  input  logic [KEY_WIDTH-1:0]      elem_key,
  input  logic [PAYLOAD_WIDTH-1:0]  elem_payload,
  output logic                      done,
  output logic [olt_pkg::ST_W-1:0]  status,
  output logic [olt_pkg::LEN_W-1:0] found_position,
  output logic [KEY_WIDTH-1:0]      out_key,
  output logic [PAYLOAD_WIDTH-1:0]  out_payload,
  output logic [olt_pkg::LEN_W-1:0] list_length,
  output logic                      list_empty
);
  import olt_pkg::*;

  localparam int CMD_W  = $bits(cmd_t);
  localparam int DATA_W = CMD_W + KEY_WIDTH + PAYLOAD_WIDTH;

  logic                     q_full;
  logic                     push;
  cmd_t                     push_cmd;
  logic [KEY_WIDTH-1:0]     push_key;
  logic [PAYLOAD_WIDTH-1:0] push_pay;
  logic [DATA_W-1:0]        push_data;
  logic                     q_valid;
  logic                     q_pop;
  logic [DATA_W-1:0]        head;
  cmd_t                     q_cmd;
  logic [KEY_WIDTH-1:0]     q_key;
  logic [PAYLOAD_WIDTH-1:0] q_pay;

  assign push_data = {push_cmd, push_key, push_pay};
  assign q_cmd     = cmd_t'(head[DATA_W-1 -: CMD_W]);
  assign q_key     = head[PAYLOAD_WIDTH +: KEY_WIDTH];
  assign q_pay     = head[PAYLOAD_WIDTH-1:0];

  olt_front #(
    .KEY_WIDTH     (KEY_WIDTH),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) u_front (
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .position     (position),
    .elem_key     (elem_key),
    .elem_payload (elem_payload),
    .q_full       (q_full),
    .push         (push),
    .push_cmd     (push_cmd),
    .push_key     (push_key),
    .push_pay     (push_pay)
  );

  olt_queue #(
    .DATA_W (DATA_W),
    .QDEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (head)
  );

  olt_back #(
    .DEPTH         (DEPTH),
    .KEY_WIDTH     (KEY_WIDTH),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_pop          (q_pop),
    .q_cmd          (q_cmd),
    .q_key          (q_key),
    .q_pay          (q_pay),
    .done           (done),
    .status         (status),
    .found_position (found_position),
    .out_key        (out_key),
    .out_payload    (out_payload),
    .list_length    (list_length),
    .list_empty     (list_empty)
  );

endmodule
